// File: sv/modular_arithmetic_unit_assert.svh
// Assertion macros for the modular arithmetic unit.
// Each macro checks on clk_i and is disabled while rst_ni is low.
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH

`define MAU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("modular arithmetic unit check failed");

`define MAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("modular arithmetic unit check failed");

`endif

// File: sv/mau_pkg.sv
// Shared types and constants for the modular arithmetic unit.
// No dependencies.
package mau_pkg;

  typedef enum logic [2:0] {
    OP_REDUCE = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_POW    = 3'd4,
    OP_INV    = 3'd5,
    OP_DIV    = 3'd6,
    OP_NEG    = 3'd7
  } op_e;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_REDA = 11'b00000000010,
    S_REDB = 11'b00000000100,
    S_REDR = 11'b00000001000,
    S_NEGR = 11'b00000010000,
    S_SUBN = 11'b00000100000,
    S_ADD  = 11'b00001000000,
    S_NEGA = 11'b00010000000,
    S_PW   = 11'b00100000000,
    S_ML   = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

  typedef enum logic [1:0] {
    TAG_FINAL = 2'd0,
    TAG_PACC  = 2'd1,
    TAG_BASE  = 2'd2
  } tag_e;

  localparam int unsigned RawW = 64;
  localparam int unsigned OpdW = 62;
  localparam int unsigned ExpW = 63;
  localparam int unsigned CntW = 7;
  localparam logic [3:0] ModulusAddr = 4'd0;

endpackage

// File: sv/modular_arithmetic_unit.sv
// Modular arithmetic unit: one shared modular add/negate unit under a sequencer.
// Each request reduces operands A and B, then runs the operation: reduce the raw value (negated
// if negative), add, sub, negate, multiply; power/inverse square and multiply per exponent bit
// (63 bits for power, MOD_WIDTH for inverse); divide multiplies A by the inverse of B.
// One request at a time; a result that waits for out_ready_i holds the sequencer. Reset sets
// the modulus to 1.
`include "modular_arithmetic_unit_assert.svh"
module modular_arithmetic_unit
  import mau_pkg::*;
#(
  parameter int unsigned MOD_WIDTH = 62
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             operation_i,
  input  logic signed [RawW-1:0] raw_value_i,
  input  logic [OpdW-1:0]        operand_a_i,
  input  logic [OpdW-1:0]        operand_b_i,
  input  logic [ExpW-1:0]        exponent_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OpdW-1:0]        result_o,
  output logic                   equal_o,
  output logic                   less_o
);

  localparam int unsigned W = MOD_WIDTH;

  state_e               state_q, state_d;
  logic [W-1:0]         mod_q;
  logic [W-1:0]         m_eff;
  logic [2:0]           op_q;
  logic [RawW-1:0]      raw_q;
  logic [OpdW-1:0]      bin_q;
  logic [ExpW-1:0]      k_q;
  logic                 eq_q, lt_q, neg_q, ph_q;
  logic [RawW-1:0]      sr_q;
  logic [CntW-1:0]      cnt_q;
  logic [W-1:0]         acc_q, ra_q, rb_q, mx_q, my_q, base_q, pacc_q, res_q;
  tag_e                 tag_q;
  logic                 out_valid_q;
  logic [OpdW-1:0]      result_q;
  logic                 equal_q, less_q;

  logic [W-1:0]         ux, uy, nx, add_res, neg_res, mul_v;
  logic                 ucin;
  logic [W:0]           sum;
  logic [W+1:0]         diff;
  logic                 red_last, mul_last;
  logic [RawW-1:0]      raw_mag;
  logic [ExpW-1:0]      inv_k;

  assign m_eff = (mod_q == '0) ? W'(1) : mod_q;

  always_comb begin
    ux   = acc_q;
    uy   = acc_q;
    ucin = 1'b0;
    nx   = acc_q;
    case (state_q)
      S_REDA, S_REDB, S_REDR: begin
        ucin = sr_q[RawW-1];
      end
      S_ML: begin
        if (ph_q) begin
          uy = mx_q;
        end
      end
      S_ADD: begin
        ux = ra_q;
        uy = rb_q;
      end
      S_SUBN: begin
        nx = rb_q;
      end
      S_NEGA: begin
        nx = ra_q;
      end
      default: begin
      end
    endcase
  end

  assign sum     = {1'b0, ux} + {1'b0, uy} + (W+1)'(ucin);
  assign diff    = {1'b0, sum} - {2'b0, m_eff};
  assign add_res = diff[W+1] ? sum[W-1:0] : diff[W-1:0];
  assign neg_res = (nx == '0) ? '0 : m_eff - nx;

  assign red_last = (cnt_q == CntW'(RawW - 1));
  assign mul_last = (cnt_q == CntW'(W - 1));
  assign mul_v    = my_q[W-1] ? add_res : acc_q;
  assign raw_mag  = raw_q[RawW-1] ? (~raw_q + RawW'(1)) : raw_q;
  assign inv_k    = (m_eff < W'(2)) ? '0 : (ExpW'(m_eff) - ExpW'(2));

  assign in_ready_o = (state_q == S_IDLE);
  assign pready     = 1'b1;
  assign prdata     = (paddr == ModulusAddr) ? 64'(mod_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= W'(1);
    end else if (psel && penable && pwrite && (paddr == ModulusAddr)) begin
      mod_q <= pwdata[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_REDA;
        end
      end
      S_REDA: begin
        if (red_last) begin
          state_d = S_REDB;
        end
      end
      S_REDB: begin
        if (red_last) begin
          case (op_e'(op_q))
            OP_REDUCE: state_d = S_REDR;
            OP_ADD:    state_d = S_ADD;
            OP_SUB:    state_d = S_SUBN;
            OP_MUL:    state_d = S_ML;
            OP_NEG:    state_d = S_NEGA;
            default:   state_d = S_PW;
          endcase
        end
      end
      S_REDR: begin
        if (red_last) begin
          state_d = neg_q ? S_NEGR : S_OUT;
        end
      end
      S_SUBN:  state_d = S_ADD;
      S_ADD, S_NEGA, S_NEGR: state_d = S_OUT;
      S_PW: begin
        if (k_q == '0) begin
          state_d = (op_e'(op_q) == OP_DIV) ? S_ML : S_OUT;
        end else begin
          state_d = S_ML;
        end
      end
      S_ML: begin
        if (ph_q && mul_last) begin
          case (tag_q)
            TAG_FINAL: state_d = S_OUT;
            TAG_BASE:  state_d = S_PW;
            default:   state_d = S_ML;
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_q  <= operation_i;
          raw_q <= raw_value_i;
          bin_q <= operand_b_i;
          k_q   <= exponent_i;
          eq_q  <= (operand_a_i == operand_b_i);
          lt_q  <= (operand_a_i < operand_b_i);
          sr_q  <= RawW'(operand_a_i);
          acc_q <= '0;
          cnt_q <= '0;
        end
      end
      S_REDA: begin
        if (red_last) begin
          ra_q  <= add_res;
          acc_q <= '0;
          sr_q  <= RawW'(bin_q);
          cnt_q <= '0;
        end else begin
          acc_q <= add_res;
          sr_q  <= sr_q << 1;
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      S_REDB: begin
        if (red_last) begin
          rb_q   <= add_res;
          acc_q  <= '0;
          cnt_q  <= '0;
          ph_q   <= 1'b0;
          sr_q   <= raw_mag;
          neg_q  <= raw_q[RawW-1];
          mx_q   <= ra_q;
          my_q   <= add_res;
          tag_q  <= TAG_FINAL;
          pacc_q <= (m_eff == W'(1)) ? '0 : W'(1);
          base_q <= (op_e'(op_q) == OP_DIV) ? add_res : ra_q;
          if (op_e'(op_q) == OP_INV || op_e'(op_q) == OP_DIV) begin
            k_q <= inv_k;
          end
        end else begin
          acc_q <= add_res;
          sr_q  <= sr_q << 1;
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      S_REDR: begin
        acc_q <= add_res;
        sr_q  <= sr_q << 1;
        cnt_q <= cnt_q + CntW'(1);
        res_q <= add_res;
      end
      S_NEGR, S_NEGA: begin
        res_q <= neg_res;
      end
      S_SUBN: begin
        rb_q <= neg_res;
      end
      S_ADD: begin
        res_q <= add_res;
      end
      S_PW: begin
        acc_q <= '0;
        cnt_q <= '0;
        ph_q  <= 1'b0;
        res_q <= pacc_q;
        if (k_q == '0) begin
          mx_q  <= ra_q;
          my_q  <= pacc_q;
          tag_q <= TAG_FINAL;
        end else if (k_q[0]) begin
          mx_q  <= pacc_q;
          my_q  <= base_q;
          tag_q <= TAG_PACC;
        end else begin
          mx_q  <= base_q;
          my_q  <= base_q;
          tag_q <= TAG_BASE;
        end
      end
      S_ML: begin
        if (!ph_q) begin
          acc_q <= add_res;
          ph_q  <= 1'b1;
        end else begin
          ph_q <= 1'b0;
          if (mul_last) begin
            acc_q <= '0;
            cnt_q <= '0;
            case (tag_q)
              TAG_FINAL: res_q <= mul_v;
              TAG_PACC: begin
                pacc_q <= mul_v;
                mx_q   <= base_q;
                my_q   <= base_q;
                tag_q  <= TAG_BASE;
              end
              default: begin
                base_q <= mul_v;
                k_q    <= k_q >> 1;
              end
            endcase
          end else begin
            acc_q <= mul_v;
            my_q  <= my_q << 1;
            cnt_q <= cnt_q + CntW'(1);
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          result_q <= OpdW'(res_q);
          equal_q  <= eq_q;
          less_q   <= lt_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign equal_o     = equal_q;
  assign less_o      = less_q;

  `MAU_ASSERT_SAME(a_result_below_mod, out_valid_o, result_o < OpdW'(m_eff))
  `MAU_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == S_REDA)
  `MAU_ASSERT_SAME(a_mul_count, state_q == S_ML, cnt_q < CntW'(W))
  `MAU_ASSERT_SAME(a_red_acc_below_mod, state_q == S_REDA || state_q == S_REDB, acc_q < m_eff)

endmodule
